>>> rtl/core/keyed_event_rate_limiter_top_macros.svh
// ----------------------------------------------------------------------------
// keyed_event_rate_limiter_top_macros.svh
// assertion macros used by the rate limiter datapath
// ----------------------------------------------------------------------------
`ifndef KEYED_EVENT_RATE_LIMITER_TOP_MACROS_SVH
`define KEYED_EVENT_RATE_LIMITER_TOP_MACROS_SVH

// same-cycle implication, disabled in reset
`define KERL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kerl assertion failed");

// next-cycle implication, disabled in reset
`define KERL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kerl assertion failed");

`endif

>>> rtl/core/kerl_pkg.sv
// ----------------------------------------------------------------------------
// kerl_pkg
// types and constants of the keyed event rate limiter
// ----------------------------------------------------------------------------
package kerl_pkg;

    localparam int KEY_ID_W = 16;
    localparam int TIME_W   = 32;
    localparam int COUNT_W  = 32;

    localparam logic CMD_CHECK = 1'b0;
    localparam logic CMD_CLEAR = 1'b1;

    typedef struct packed {
        logic                command;
        logic                key_present;
        logic [KEY_ID_W-1:0] key_id;
        logic [TIME_W-1:0]   window_ms;
        logic [TIME_W-1:0]   now_ms;
    } req_t;

    typedef struct packed {
        logic               allow;
        logic [COUNT_W-1:0] suppressed_count;
    } res_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_EXEC,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic take_item;
        logic scan_en;
        logic commit;
        logic reply;
    } ctl_cmd_t;

    typedef struct packed {
        logic req_check;
        logic scan_done;
        logic out_free;
    } dp_sts_t;

endpackage

>>> rtl/core/kerl_ram.sv
// ----------------------------------------------------------------------------
// kerl_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module kerl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/core/kerl_ctrl.sv
// ----------------------------------------------------------------------------
// kerl_ctrl
// sequencer: accept, slot scan, commit and reply
// ----------------------------------------------------------------------------
module kerl_ctrl
    import kerl_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     req_valid,
    output logic     req_stall,
    input  dp_sts_t  sts,
    output ctl_cmd_t cmd
);

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        req_stall  = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                req_stall     = 1'b0;
                cmd.take_item = req_valid;
                if (req_valid)
                begin
                    state_next = sts.req_check ? ST_SCAN : ST_RESP;
                end
            end
            ST_SCAN:
            begin
                cmd.scan_en = 1'b1;
                if (sts.scan_done)
                begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                if (sts.out_free)
                begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RESP:
            begin
                if (sts.out_free)
                begin
                    cmd.reply  = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

>>> rtl/core/kerl_dp.sv
// ----------------------------------------------------------------------------
// kerl_dp
// slot table, scan pipeline, window check and output word register
// ----------------------------------------------------------------------------
`include "keyed_event_rate_limiter_top_macros.svh"

module kerl_dp
    import kerl_pkg::*;
#(
    parameter int SLOTS    = 8,
    parameter int KEY_BITS = 16
) (
    input  logic     clk,
    input  logic     rst_n,
    input  req_t     req,
    input  ctl_cmd_t cmd,
    output dp_sts_t  sts,
    output logic     rsp_valid,
    input  logic     rsp_stall,
    output res_t     rsp
);

    localparam int KW       = (KEY_BITS < KEY_ID_W) ? KEY_BITS : KEY_ID_W;
    localparam int IW       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int ENTRY_W  = KW + TIME_W + COUNT_W;
    localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

    req_t                 item_reg;
    logic [SLOTS-1:0]     valid_reg;
    logic [IW-1:0]        rd_idx_reg;
    logic [IW-1:0]        cmp_idx_reg;
    logic                 cmp_vld_reg;
    logic                 issue_done_reg;
    logic                 found_reg;
    logic [IW-1:0]        sel_idx_reg;
    logic [TIME_W-1:0]    sel_time_reg;
    logic [COUNT_W-1:0]   sel_count_reg;
    logic                 free_found_reg;
    logic [IW-1:0]        free_idx_reg;
    logic                 rsp_valid_reg;
    res_t                 rsp_reg;

    logic                 rd_en;
    logic [ENTRY_W-1:0]   rd_data;
    logic [KW-1:0]        rd_key;
    logic [TIME_W-1:0]    rd_time;
    logic [COUNT_W-1:0]   rd_count;
    logic                 hit;
    logic [KW-1:0]        item_key;

    logic [IW-1:0]        slot;
    logic [TIME_W-1:0]    cur_time;
    logic [COUNT_W-1:0]   cur_count;
    logic [TIME_W-1:0]    elapsed;
    logic [TIME_W-1:0]    new_time;
    logic [COUNT_W-1:0]   new_count;
    res_t                 res;
    logic [ENTRY_W-1:0]   wr_data;

    assign item_key = item_reg.key_id[KW-1:0];
    assign rd_key   = rd_data[ENTRY_W-1 -: KW];
    assign rd_time  = rd_data[COUNT_W +: TIME_W];
    assign rd_count = rd_data[COUNT_W-1:0];
    assign rd_en    = cmd.scan_en && !issue_done_reg;
    assign hit      = cmp_vld_reg && valid_reg[cmp_idx_reg] && (rd_key == item_key);

    assign sts.req_check = (req.command == CMD_CHECK) && req.key_present;
    assign sts.scan_done = hit || (cmp_vld_reg && (cmp_idx_reg == LAST_IDX));
    assign sts.out_free  = !rsp_valid_reg || !rsp_stall;

    kerl_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (SLOTS),
        .AW    (IW)
    ) u_slot_ram (
        .clk     (clk),
        .we      (cmd.commit),
        .wr_addr (slot),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_idx_reg),
        .rd_data (rd_data)
    );

    // window check on the chosen slot
    always_comb
    begin
        slot      = found_reg ? sel_idx_reg : (free_found_reg ? free_idx_reg : '0);
        cur_time  = found_reg ? sel_time_reg : '0;
        cur_count = found_reg ? sel_count_reg : '0;
        elapsed   = item_reg.now_ms - cur_time;
        res       = '0;
        new_time  = cur_time;
        new_count = cur_count;
        if (cur_time == '0)
        begin
            res.allow = 1'b1;
            new_time  = item_reg.now_ms;
        end
        else if (elapsed < item_reg.window_ms)
        begin
            new_count = cur_count + COUNT_W'(1);
        end
        else
        begin
            res.allow            = 1'b1;
            res.suppressed_count = cur_count;
            new_count            = '0;
            new_time             = item_reg.now_ms;
        end
        wr_data = {item_key, new_time, new_count};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_item)
        begin
            item_reg <= req;
        end
        if (cmd.scan_en && hit)
        begin
            sel_idx_reg   <= cmp_idx_reg;
            sel_time_reg  <= rd_time;
            sel_count_reg <= rd_count;
        end
        if (cmd.scan_en && cmp_vld_reg && !valid_reg[cmp_idx_reg] && !free_found_reg)
        begin
            free_idx_reg <= cmp_idx_reg;
        end
        if (rd_en)
        begin
            cmp_idx_reg <= rd_idx_reg;
        end
        if (cmd.commit)
        begin
            rsp_reg <= res;
        end
        else if (cmd.reply)
        begin
            rsp_reg.allow            <= (item_reg.command == CMD_CHECK);
            rsp_reg.suppressed_count <= '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg      <= '0;
            rd_idx_reg     <= '0;
            cmp_vld_reg    <= 1'b0;
            issue_done_reg <= 1'b0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.take_item)
            begin
                rd_idx_reg     <= '0;
                cmp_vld_reg    <= 1'b0;
                issue_done_reg <= 1'b0;
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            else if (cmd.scan_en)
            begin
                cmp_vld_reg <= rd_en;
                if (rd_en)
                begin
                    if (rd_idx_reg == LAST_IDX)
                    begin
                        issue_done_reg <= 1'b1;
                    end
                    else
                    begin
                        rd_idx_reg <= rd_idx_reg + IW'(1);
                    end
                end
                if (hit)
                begin
                    found_reg <= 1'b1;
                end
                if (cmp_vld_reg && !valid_reg[cmp_idx_reg])
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (cmd.commit)
            begin
                valid_reg[slot] <= 1'b1;
            end
            else if (cmd.reply && (item_reg.command == CMD_CLEAR))
            begin
                valid_reg <= '0;
            end
            if (cmd.commit || cmd.reply)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    `KERL_ASSERT_NOW(a_write_needs_room, clk, rst_n, cmd.commit || cmd.reply, sts.out_free)
    `KERL_ASSERT_NOW(a_hit_slot_valid, clk, rst_n, cmd.commit && found_reg,
        valid_reg[sel_idx_reg])
    `KERL_ASSERT_NEXT(a_clear_empties, clk, rst_n,
        cmd.reply && (item_reg.command == CMD_CLEAR), valid_reg == '0)
    `KERL_ASSERT_NEXT(a_commit_marks, clk, rst_n, cmd.commit, valid_reg != '0)

endmodule

>>> rtl/core/keyed_event_rate_limiter_top.sv
// ----------------------------------------------------------------------------
// keyed_event_rate_limiter_top
// keyed event rate limiter with per-key suppression count
// ----------------------------------------------------------------------------
// Handles one request word at a time. A check with a key scans the slot table
// one read per cycle, which sets the latency. Its result word reaches the
// output register after the slot reads, the registered read data compare and
// a commit step that waits while the output register still holds an
// unaccepted result. The scan ends early when the key matches an early slot.
// The result of a clear or of a check without a key is written to the output
// register from the reply state, which waits the same way. A finished result
// waits in the output register while the next request is accepted. After
// reset the table is empty, and no clearing pass is needed.
// ----------------------------------------------------------------------------
module keyed_event_rate_limiter_top
    import kerl_pkg::*;
#(
    parameter int SLOTS    = 8,
    parameter int KEY_BITS = 16
) (
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_stall,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_stall,
    output res_t rsp
);

    ctl_cmd_t cmd;
    dp_sts_t  sts;

    kerl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .sts       (sts),
        .cmd       (cmd)
    );

    kerl_dp #(
        .SLOTS    (SLOTS),
        .KEY_BITS (KEY_BITS)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .cmd       (cmd),
        .sts       (sts),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp       (rsp)
    );

endmodule
